/* src/futex_wait_queue_table_defines.svh */
// Assertion macros for the futex wait-queue table RTL
`ifndef FUTEX_WAIT_QUEUE_TABLE_DEFINES_SVH
`define FUTEX_WAIT_QUEUE_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FWQT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FWQT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FWQT_ASSERT_IMP(lbl, ante, cons, msg)
`define FWQT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* src/fwqt_pkg.sv */
// Types and constants of the futex wait-queue table
package fwqt_pkg;

  localparam int TABLE_SIZE = 64;
  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_FULL     = 3'd2,
    ST_WOKEN    = 3'd3,
    ST_NONE     = 3'd4,
    ST_NOPROC   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_DIRECT = 2'd0,
    OP_WAIT   = 2'd1,
    OP_WAKE   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE  = 2'd0,
    B_WSCAN = 2'd1,
    B_SCAN  = 2'd2,
    B_FLUSH = 2'd3
  } bstate_t;

  typedef struct packed {
    logic        kind;
    logic        process_present;
    logic [31:0] caller_pid;
    logic [63:0] wait_address;
    logic [31:0] expected_value;
    logic [31:0] observed_value;
    logic [31:0] wake_limit;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] woken_pid;
    logic        last;
  } out_item_t;

  // Classified command passed from front to back
  typedef struct packed {
    op_t         op;
    status_t     status;
    logic [31:0] pid;
    logic [63:0] addr;
    logic [31:0] limit;
  } cmd_t;

endpackage

/* src/futex_wait_queue_table.sv */
// No-process, mismatch and zero-limit items pass the front register, the queue slot and the result register.
// A wait walks the used flags one entry a cycle, looking for the lowest free entry.
// A wake reads one table entry a cycle from the single memory read port, unless a match stalls on a full result.
// Throughput: one item at a time in the back end; the front and a two-deep queue take more.
// Reset (rst_n, synchronous, active low) clears all used flags at once; no clearing pass.
module futex_wait_queue_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fwqt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fwqt_pkg::out_item_t out_data
);
  import fwqt_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd_data;
  logic q_valid;
  logic q_ready;
  cmd_t q_data;

  // Accept and classify
  fwqt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data)
  );

  // Decouple front from back
  fwqt_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .push_data  (cmd_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // Execute against the waiter table
  fwqt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_data  (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* src/fwqt_front.sv */
// Front stage: accept input transactions and classify them into commands
module fwqt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fwqt_pkg::in_item_t in_data,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output fwqt_pkg::cmd_t   cmd_data
);
  import fwqt_pkg::*;

  logic cmd_v_r;
  logic cmd_v_nxt;
  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic accept;
  logic push;

  assign push      = cmd_v_r && cmd_ready;
  assign in_ready  = !cmd_v_r || cmd_ready;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = cmd_v_r;
  assign cmd_data  = cmd_r;

  // Classify the incoming transaction
  always_comb begin
    cmd_nxt        = cmd_r;
    cmd_v_nxt      = cmd_v_r;
    if (push) begin
      cmd_v_nxt = 1'b0;
    end
    if (accept) begin
      cmd_v_nxt      = 1'b1;
      cmd_nxt.pid    = in_data.caller_pid;
      cmd_nxt.addr   = in_data.wait_address;
      cmd_nxt.limit  = in_data.wake_limit;
      cmd_nxt.op     = OP_DIRECT;
      cmd_nxt.status = ST_NOPROC;
      if (in_data.process_present) begin
        if (!in_data.kind) begin
          if (in_data.observed_value != in_data.expected_value) begin
            cmd_nxt.status = ST_MISMATCH;
          end else begin
            cmd_nxt.op = OP_WAIT;
          end
        end else if (in_data.wake_limit == 32'd0) begin
          cmd_nxt.status = ST_NONE;
        end else begin
          cmd_nxt.op = OP_WAKE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_v_r <= 1'b0;
    end else begin
      cmd_v_r <= cmd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

/* src/fwqt_fifo.sv */
// Short command queue between front and back
module fwqt_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  fwqt_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output fwqt_pkg::cmd_t pop_data
);
  import fwqt_pkg::*;

  cmd_t                  slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (cnt_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/fwqt_back.sv */
// Back end: waiter table, wait claim scan, wake scan and result register
`include "futex_wait_queue_table_defines.svh"
module fwqt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  fwqt_pkg::cmd_t     cmd_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fwqt_pkg::out_item_t out_data
);
  import fwqt_pkg::*;

  // Waiter table storage
  logic [31:0] mem_pid  [TABLE_SIZE];
  logic [63:0] mem_addr [TABLE_SIZE];

  bstate_t              state_r,     state_nxt;
  logic [TABLE_SIZE-1:0] used_r,     used_nxt;
  logic [CNT_W-1:0]     issue_idx_r, issue_idx_nxt;
  logic [CNT_W-1:0]     wk_cnt_r,    wk_cnt_nxt;
  logic                 chk_v_r,     chk_v_nxt;
  logic [IDX_W-1:0]     chk_idx_r,   chk_idx_nxt;
  logic                 pend_v_r,    pend_v_nxt;
  logic [31:0]          pend_pid_r,  pend_pid_nxt;
  logic [31:0]          pid_r,       pid_nxt;
  logic [63:0]          addr_r,      addr_nxt;
  logic [31:0]          lim_r,       lim_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r,  out_data_nxt;
  logic [31:0]          rd_pid_r;
  logic [63:0]          rd_addr_r;

  logic             out_free;
  logic             match;
  logic             stall;
  logic             issue_more;
  logic [IDX_W-1:0] rd_sel;
  logic [IDX_W-1:0] scan_idx;
  logic             mem_we;
  logic             emit;
  out_item_t        emit_item;
  logic [31:0]      wk_cnt_ext;
  logic [31:0]      wk_cnt_nxt_ext;

  assign out_free   = !out_valid_r || out_ready;
  assign scan_idx   = issue_idx_r[IDX_W-1:0];
  assign match      = chk_v_r && used_r[chk_idx_r] &&
                      (rd_pid_r == pid_r) && (rd_addr_r == addr_r);
  assign stall      = match && pend_v_r && !out_free;
  assign rd_sel     = stall ? chk_idx_r : scan_idx;
  assign wk_cnt_ext = {{(32-CNT_W){1'b0}}, wk_cnt_r};
  assign wk_cnt_nxt_ext = {{(32-CNT_W){1'b0}}, wk_cnt_nxt};

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state, table updates and result generation
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    issue_idx_nxt = issue_idx_r;
    wk_cnt_nxt    = wk_cnt_r;
    chk_v_nxt     = chk_v_r;
    chk_idx_nxt   = chk_idx_r;
    pend_v_nxt    = pend_v_r;
    pend_pid_nxt  = pend_pid_r;
    pid_nxt       = pid_r;
    addr_nxt      = addr_r;
    lim_nxt       = lim_r;
    cmd_ready     = 1'b0;
    mem_we        = 1'b0;
    emit          = 1'b0;
    emit_item     = '{status: ST_NONE, woken_pid: 32'd0, last: 1'b1};
    issue_more    = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          case (cmd_data.op)
            OP_DIRECT: begin
              if (out_free) begin
                cmd_ready        = 1'b1;
                emit             = 1'b1;
                emit_item.status = cmd_data.status;
              end
            end
            OP_WAIT: begin
              cmd_ready     = 1'b1;
              pid_nxt       = cmd_data.pid;
              addr_nxt      = cmd_data.addr;
              issue_idx_nxt = '0;
              state_nxt     = B_WSCAN;
            end
            OP_WAKE: begin
              cmd_ready     = 1'b1;
              pid_nxt       = cmd_data.pid;
              addr_nxt      = cmd_data.addr;
              lim_nxt       = cmd_data.limit;
              issue_idx_nxt = '0;
              wk_cnt_nxt    = '0;
              chk_v_nxt     = 1'b0;
              pend_v_nxt    = 1'b0;
              state_nxt     = B_SCAN;
            end
            default: begin
              cmd_ready = 1'b1;
            end
          endcase
        end
      end

      // Walk the used flags for the lowest free entry
      B_WSCAN: begin
        if (issue_idx_r == CNT_W'(TABLE_SIZE)) begin
          if (out_free) begin
            emit             = 1'b1;
            emit_item.status = ST_FULL;
            state_nxt        = B_IDLE;
          end
        end else if (!used_r[scan_idx]) begin
          if (out_free) begin
            used_nxt[scan_idx] = 1'b1;
            mem_we             = 1'b1;
            emit               = 1'b1;
            emit_item.status   = ST_QUEUED;
            state_nxt          = B_IDLE;
          end
        end else begin
          issue_idx_nxt = issue_idx_r + 1'b1;
        end
      end

      // Read one entry per cycle unless stalled, check the one read last cycle
      B_SCAN: begin
        if (!stall) begin
          if (match) begin
            used_nxt[chk_idx_r] = 1'b0;
            wk_cnt_nxt          = wk_cnt_r + 1'b1;
            pend_v_nxt          = 1'b1;
            pend_pid_nxt        = rd_pid_r;
            if (pend_v_r) begin
              emit      = 1'b1;
              emit_item = '{status: ST_WOKEN, woken_pid: pend_pid_r, last: 1'b0};
            end
          end
          issue_more  = (issue_idx_r != CNT_W'(TABLE_SIZE)) && (wk_cnt_nxt_ext < lim_r);
          chk_v_nxt   = issue_more;
          chk_idx_nxt = scan_idx;
          if (issue_more) begin
            issue_idx_nxt = issue_idx_r + 1'b1;
          end else begin
            state_nxt = B_FLUSH;
          end
        end
      end

      // Release the held result as the final one
      B_FLUSH: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend_v_r) begin
            emit_item = '{status: ST_WOKEN, woken_pid: pend_pid_r, last: 1'b1};
          end
          pend_v_nxt = 1'b0;
          state_nxt  = B_IDLE;
        end
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    // Result register: load on emit, drop once taken
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_item;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      used_r      <= '0;
      issue_idx_r <= '0;
      wk_cnt_r    <= '0;
      chk_v_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      issue_idx_r <= issue_idx_nxt;
      wk_cnt_r    <= wk_cnt_nxt;
      chk_v_r     <= chk_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    pend_pid_r <= pend_pid_nxt;
    pid_r      <= pid_nxt;
    addr_r     <= addr_nxt;
    lim_r      <= lim_nxt;
    out_data_r <= out_data_nxt;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_pid[scan_idx]  <= pid_r;
      mem_addr[scan_idx] <= addr_r;
    end
    rd_pid_r  <= mem_pid[rd_sel];
    rd_addr_r <= mem_addr[rd_sel];
  end

  `FWQT_ASSERT_IMP(a_woken_within_limit, state_r == B_SCAN, wk_cnt_ext <= lim_r, "wake freed more entries than its limit")
  `FWQT_ASSERT_IMP(a_partial_only_in_wake, out_valid_r && !out_data_r.last, state_r == B_SCAN || state_r == B_FLUSH, "non-final result outside a wake")
  `FWQT_ASSERT_IMP(a_pending_only_in_wake, pend_v_r, state_r == B_SCAN || state_r == B_FLUSH, "held waiter outside a wake")
  `FWQT_ASSERT_NXT(a_stall_keeps_check, stall, chk_v_r && chk_idx_r == $past(chk_idx_r), "stalled match lost")

endmodule

/* tb/sv/futex_wait_queue_table_tb.sv */
// Self-checking testbench for the futex wait-queue table: random and directed transactions
`timescale 1ns / 1ps

module futex_wait_queue_table_tb;
  import fwqt_pkg::*;

  localparam logic KIND_WAIT = 1'b0;
  localparam logic KIND_WAKE = 1'b1;
  localparam int   TARGET_REQS = 430;
  localparam int   STALL_LIMIT = 4000;
  localparam int   HOLD_CYCLES = 400;
  localparam int   IDLE_PCT = 19;

  typedef struct {
    in_item_t item;
    bit       drain_first;
  } pend_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Stimulus and expectation stores
  pend_t       pend_q[$];
  out_item_t   result_q[$];
  bit          drain_next = 1'b0;
  int          stim_cnt = 0;

  // Predicted waiter table
  logic        tbl_used [TABLE_SIZE];
  logic [31:0] tbl_pid  [TABLE_SIZE];
  logic [63:0] tbl_addr [TABLE_SIZE];

  logic [31:0] pid_pool  [4];
  logic [63:0] addr_pool [4];

  // Progress and statistics
  logic        in_hs = 1'b0;
  int          taken_cnt = 0;
  int          results_seen = 0;
  int          fail_cnt = 0;
  int          stall_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          n_waits = 0, n_wakes = 0, n_noproc = 0;
  int          n_queued = 0, n_mismatch = 0, n_full = 0, n_woken = 0, n_none = 0;
  int          max_released = 0;
  bit          calm;

  futex_wait_queue_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // No idling on either side over one stretch of the run
  assign calm = (taken_cnt >= 200) && (taken_cnt < 280);

  // Work out the results of one accepted request and update the table
  task automatic predict_futex(input in_item_t it);
    out_item_t   r;
    out_item_t   held;
    bit          have_held;
    int          slot;
    int unsigned freed;
    r.status = ST_NONE;
    r.woken_pid = '0;
    r.last = 1'b1;
    held = r;
    have_held = 1'b0;
    slot = -1;
    freed = 0;
    if (!it.process_present) begin
      r.status = ST_NOPROC;
      n_noproc++;
      result_q.push_back(r);
    end else if (it.kind == KIND_WAIT) begin
      n_waits++;
      if (it.observed_value != it.expected_value) begin
        r.status = ST_MISMATCH;
        n_mismatch++;
      end else begin
        for (int i = 0; i < TABLE_SIZE && slot < 0; i++)
          if (!tbl_used[i]) slot = i;
        if (slot < 0) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          tbl_used[slot] = 1'b1;
          tbl_pid[slot] = it.caller_pid;
          tbl_addr[slot] = it.wait_address;
          r.status = ST_QUEUED;
          n_queued++;
        end
      end
      result_q.push_back(r);
    end else begin
      n_wakes++;
      // Free matching waiters in index order; the final one carries last
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (freed < it.wake_limit && tbl_used[i] && tbl_pid[i] == it.caller_pid &&
            tbl_addr[i] == it.wait_address) begin
          tbl_used[i] = 1'b0;
          if (have_held) result_q.push_back(held);
          held.status = ST_WOKEN;
          held.woken_pid = tbl_pid[i];
          held.last = 1'b0;
          have_held = 1'b1;
          freed++;
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        result_q.push_back(held);
        n_woken += freed;
        if (freed > max_released) max_released = freed;
      end else begin
        r.status = ST_NONE;
        n_none++;
        result_q.push_back(r);
      end
    end
  endtask

  // Compare one result with the oldest expectation
  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (result_q.size() == 0) begin
      $error("unexpected result: status %0d woken_pid %h last %b",
             got.status, got.woken_pid, got.last);
      fail_cnt++;
    end else begin
      want = result_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_cnt++;
      end
      if (got.woken_pid !== want.woken_pid) begin
        $error("woken_pid: expected %h, got %h", want.woken_pid, got.woken_pid);
        fail_cnt++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, got %b", want.last, got.last);
        fail_cnt++;
      end
    end
  endtask

  function automatic in_item_t make_req(input logic kind, input logic present,
                                        input logic [31:0] pid, input logic [63:0] addr,
                                        input logic [31:0] expv, input logic [31:0] obsv,
                                        input logic [31:0] lim);
    in_item_t it;
    it.kind = kind;
    it.process_present = present;
    it.caller_pid = pid;
    it.wait_address = addr;
    it.expected_value = expv;
    it.observed_value = obsv;
    it.wake_limit = lim;
    return it;
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return 32'd1;
      3:       return 32'd2;
      4, 5:    return $urandom_range(3, 8);
      6:       return TABLE_SIZE;
      7:       return '1;
      8:       return $urandom;
      default: return $urandom_range(9, 70);
    endcase
  endfunction

  task automatic add_req(input in_item_t it);
    pend_t p;
    p.item = it;
    p.drain_first = drain_next;
    drain_next = 1'b0;
    pend_q.push_back(p);
    stim_cnt++;
  endtask

  // Well-formed traffic over a small set of pids and addresses
  task automatic queue_burst(input int n);
    logic [31:0] v;
    for (int k = 0; k < n; k++) begin
      v = $urandom;
      add_req(make_req(($urandom_range(9) < 6) ? KIND_WAIT : KIND_WAKE,
                       $urandom_range(19) != 0, pid_pool[$urandom_range(3)],
                       addr_pool[$urandom_range(3)], v,
                       ($urandom_range(3) != 0) ? v : $urandom, pick_limit()));
    end
  endtask

  // Release every waiter that belongs to the pools
  task automatic queue_sweep();
    for (int p = 0; p < 4; p++)
      for (int a = 0; a < 4; a++)
        add_req(make_req(KIND_WAKE, 1'b1, pid_pool[p], addr_pool[a], $urandom, $urandom, '1));
  endtask

  // Fill the table past capacity, then empty it again
  task automatic queue_fill();
    int unsigned pi;
    int unsigned ai;
    bit          one_key;
    logic [31:0] v;
    one_key = 1'($urandom_range(1));
    pi = $urandom_range(3);
    ai = $urandom_range(3);
    for (int k = 0; k < TABLE_SIZE + 2; k++) begin
      if (!one_key) begin
        pi = $urandom_range(3);
        ai = $urandom_range(3);
      end
      v = $urandom;
      add_req(make_req(KIND_WAIT, 1'b1, pid_pool[pi], addr_pool[ai], v, v, $urandom));
    end
    if (one_key)
      add_req(make_req(KIND_WAKE, 1'b1, pid_pool[pi], addr_pool[ai], $urandom, $urandom, '1));
    else
      queue_sweep();
  endtask

  // Unstructured requests with full-range fields
  task automatic queue_noise();
    logic [31:0] v;
    for (int k = 0; k < 4; k++) begin
      v = $urandom;
      add_req(make_req(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                       {$urandom, $urandom},
                       v, ($urandom_range(7) == 0) ? v : $urandom,
                       ($urandom_range(1) != 0) ? $urandom : pick_limit()));
    end
  endtask

  // Fill the stimulus queue, release reset, then wait for the run to drain
  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tbl_used[i] = 1'b0;
      tbl_pid[i] = '0;
      tbl_addr[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      pid_pool[i] = $urandom;
      addr_pool[i] = {$urandom, $urandom};
    end

    // Directed: no process, mismatch, zero limit, partial and full wakes
    add_req(make_req(KIND_WAIT, 1'b0, '1, '1, '1, '1, '1));
    add_req(make_req(KIND_WAKE, 1'b0, '0, '0, '0, '0, '0));
    add_req(make_req(KIND_WAKE, 1'b1, '0, '0, '0, '0, '1));
    add_req(make_req(KIND_WAIT, 1'b1, '0, '0, '0, '1, '0));
    add_req(make_req(KIND_WAIT, 1'b1, '0, '0, '0, '0, '0));
    add_req(make_req(KIND_WAIT, 1'b1, '1, '1, '1, '1, '1));
    add_req(make_req(KIND_WAIT, 1'b1, '0, '0, 32'h5a5a_a5a5, 32'h5a5a_a5a5, '0));
    add_req(make_req(KIND_WAIT, 1'b1, '0, '1, 32'h1234_5678, 32'h1234_5678, '0));
    add_req(make_req(KIND_WAKE, 1'b1, '0, '0, '0, '0, '0));
    add_req(make_req(KIND_WAKE, 1'b1, '0, '0, '0, '0, 32'd1));
    add_req(make_req(KIND_WAIT, 1'b1, '0, '0, '1, '1, '0));
    add_req(make_req(KIND_WAKE, 1'b1, '0, '0, '0, '0, '1));
    add_req(make_req(KIND_WAKE, 1'b1, '1, '0, '1, '1, '1));
    add_req(make_req(KIND_WAKE, 1'b1, '1, '1, '0, '0, '1));
    add_req(make_req(KIND_WAKE, 1'b1, '0, '1, '0, '0, 32'd2));
    add_req(make_req(KIND_WAIT, 1'b1, '1, '0, '1, '0, '1));
    add_req(make_req(KIND_WAKE, 1'b1, pid_pool[0], addr_pool[0], '0, '0, 32'h8000_0000));

    // Random: pause once for an empty pipeline, fill the table, then mix
    drain_next = 1'b1;
    queue_fill();
    while (stim_cnt < TARGET_REQS) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: queue_burst($urandom_range(6, 20));
        5:             queue_fill();
        6:             queue_sweep();
        7, 9:          queue_noise();
        default: begin
          drain_next = 1'b1;
          queue_burst($urandom_range(6, 20));
        end
      endcase
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_valid) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (TABLE_SIZE + 16) @(posedge clk);

    $display("Checked %0d results from %0d requests: %0d waits, %0d wakes, %0d with no process.",
             results_seen, taken_cnt, n_waits, n_wakes, n_noproc);
    $display("Queued %0d, mismatched %0d, rejected full %0d, released %0d (at most %0d at once), none %0d.",
             n_queued, n_mismatch, n_full, n_woken, max_released, n_none);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Driver: offer the next request at the falling edge, hold it until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_hs) begin
      if (pend_q.size() != 0 && !(pend_q[0].drain_first && result_q.size() != 0) &&
          (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_data <= pend_q[0].item;
        in_valid <= 1'b1;
        pend_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 120) begin
      out_ready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: check results, then predict for the accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_hs <= 1'b0;
    end else begin
      in_hs <= in_valid && in_ready;
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) begin
        predict_futex(in_data);
        taken_cnt++;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

/* files.f */
+incdir+src
src/fwqt_pkg.sv
src/fwqt_front.sv
src/fwqt_fifo.sv
src/fwqt_back.sv
src/futex_wait_queue_table.sv
tb/sv/futex_wait_queue_table_tb.sv
